// ===== hw/rtl/sii_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sii_pkg: shared types and constants of the SII EEPROM emulator
// Opcodes, CRC-8 constants, stream field widths and store defaults.
// ----------------------------------------------------------------------------
package sii_pkg;

  localparam int unsigned OPCODE_W = 2;

  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RELOAD = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_UNSUP  = 2'd3;

  localparam logic [7:0]  CRC_INIT   = 8'hFF;
  localparam logic [7:0]  CRC_POLY   = 8'h07;
  localparam logic [7:0]  CRC_TOP    = 8'h80;
  localparam logic [15:0] BLANK_WORD = 16'hFFFF;

  // Header CRC covers fourteen bytes; the check byte sits in the next word.
  localparam int unsigned CRC_BYTES  = 14;
  localparam logic [2:0]  CHECK_WORD = 3'(CRC_BYTES / 2);
  localparam logic [2:0]  LINK_WORD  = 3'd0;
  localparam logic [2:0]  ALIAS_WORD = 3'd4;

  localparam int unsigned STORE_WORDS_DEF = 1024;

  // busy_req, word_address, read_four_words, write_word -> 34 bits, padded
  localparam int unsigned IN_DATA_W  = 40;
  // acknowledged, data_valid, result_data, command_error, checksum_error
  localparam int unsigned OUT_DATA_W = 72;

endpackage
`default_nettype wire

// ===== hw/rtl/sii_crc8.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sii_crc8: byte-serial CRC-8 unit
// Folds one byte per step into a running CRC-8, MSB first.
// ----------------------------------------------------------------------------
module sii_crc8 (
  input  wire logic       clk_i,
  input  wire logic       init_i,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output      logic [7:0] crc_o
);
  import sii_pkg::*;

  logic [7:0] crc_q;
  logic [7:0] crc_d;

  always_comb begin
    logic [7:0] c;
    c = crc_q ^ byte_i;
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    crc_d = c;
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      crc_q <= CRC_INIT;
    end else if (step_i) begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sii_eeprom_emulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sii_eeprom_emulator: EEPROM command server for an SII word store
// Read, write and reload commands over a store of 16-bit words.
// ----------------------------------------------------------------------------
// Reset: the store is swept to all ones, one word per cycle; no item is
//   taken during the sweep, config writes are.
// Write, unsupported or ignored command: straight to output. Read: fetch,
//   use per word, N = 2 or 4 words. Reload: seven header words take fetch,
//   low and high CRC byte steps, then check word fetch, compare.
// One item at a time: the next enters in the cycle after the result loads.
module sii_eeprom_emulator #(
  parameter int unsigned STORE_WORDS = sii_pkg::STORE_WORDS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // emulation_enabled
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // busy_req[0], word_address[16:1], read_four_words[17], write_word[33:18]
  input  wire logic [sii_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  wire logic [sii_pkg::OPCODE_W-1:0]    s_axis_tuser,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // acknowledged[0], data_valid[1], result_data[65:2], command_error[66],
  // checksum_error[67]
  output      logic [sii_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import sii_pkg::*;

  localparam int unsigned AW          = $clog2(STORE_WORDS);
  localparam logic [AW-1:0] CLR_LAST  = AW'(STORE_WORDS - 1);
  localparam logic [16:0] STORE_LIMIT = 17'(STORE_WORDS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_USE   = 3'd3;
  localparam logic [2:0] S_HIGH  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic          en_q;
  logic [AW-1:0] clr_q;
  logic [2:0]    idx_q;
  logic          m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // Latched command and working result
  logic [OPCODE_W-1:0] op_q;
  logic [15:0]   addr_q;
  logic          four_q;
  logic          oob_q;
  logic [15:0]   rdata_q;
  logic          ack_q, dv_q, cerr_q, serr_q;
  logic [63:0]   data_q;

  logic [15:0]   mem [STORE_WORDS];

  // Input unpack
  logic          in_busy, in_four, in_active, in_addr_ok;
  logic [15:0]   in_addr, in_wdata;
  logic [OPCODE_W-1:0] in_op;
  logic          accept;

  assign in_op      = s_axis_tuser;
  assign in_busy    = s_axis_tdata[0];
  assign in_addr    = s_axis_tdata[16:1];
  assign in_four    = s_axis_tdata[17];
  assign in_wdata   = s_axis_tdata[33:18];
  assign in_active  = en_q && in_busy;
  assign in_addr_ok = {1'b0, in_addr} < STORE_LIMIT;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Store write port: clearing sweep, else an in-range write command
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          clearing;

  assign clearing = (state_q == S_CLEAR);
  assign mem_we   = clearing ||
                    (accept && in_active && (in_op == OP_WRITE) && in_addr_ok);
  assign mem_wa   = clearing ? clr_q : in_addr[AW-1:0];
  assign mem_wd   = clearing ? BLANK_WORD : in_wdata;

  // Fetch address: reload walks the header from word zero, reads do not wrap
  logic [16:0] fetch_addr;
  logic        fetch_oob;
  logic [15:0] word;
  logic [2:0]  last_idx;

  assign fetch_addr = ((op_q == OP_RELOAD) ? 17'd0 : {1'b0, addr_q}) + 17'(idx_q);
  assign fetch_oob  = fetch_addr >= STORE_LIMIT;
  assign word       = oob_q ? BLANK_WORD : rdata_q;
  assign last_idx   = four_q ? 3'd3 : 3'd1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state_q == S_FETCH) begin
      rdata_q <= mem[fetch_addr[AW-1:0]];
    end
  end

  // Reload CRC unit: low byte in the use step, high byte in the next one
  logic       crc_step;
  logic [7:0] crc_byte;
  logic [7:0] crc;

  assign crc_step = ((state_q == S_USE) && (op_q == OP_RELOAD) && (idx_q != CHECK_WORD))
                    || (state_q == S_HIGH);
  assign crc_byte = (state_q == S_HIGH) ? rdata_q[15:8] : rdata_q[7:0];

  sii_crc8 u_crc (
    .clk_i  (clk_i),
    .init_i (accept),
    .step_i (crc_step),
    .byte_i (crc_byte),
    .crc_o  (crc)
  );

  logic out_free;
  logic out_load;

  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == S_DONE) && out_free;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_active && ((in_op == OP_READ) || (in_op == OP_RELOAD))) begin
            state_d = S_FETCH;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_FETCH: state_d = S_USE;
      S_USE: begin
        if (op_q == OP_READ) begin
          state_d = (idx_q == last_idx) ? S_DONE : S_FETCH;
        end else begin
          state_d = (idx_q == CHECK_WORD) ? S_DONE : S_HIGH;
        end
      end
      S_HIGH: state_d = S_FETCH;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      en_q      <= 1'b0;
      clr_q     <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (clearing) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        idx_q <= '0;
      end else if (state_q == S_USE) begin
        idx_q <= idx_q + 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Command latch and result assembly
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_op;
      addr_q <= in_addr;
      four_q <= in_four;
      ack_q  <= in_active;
      dv_q   <= 1'b0;
      data_q <= '0;
      cerr_q <= in_active &&
                ((in_op == OP_UNSUP) || ((in_op == OP_WRITE) && !in_addr_ok));
      serr_q <= 1'b0;
    end
    if (state_q == S_FETCH) begin
      oob_q <= fetch_oob;
    end
    if (state_q == S_USE) begin
      if (op_q == OP_READ) begin
        data_q[{idx_q[1:0], 4'b0000} +: 16] <= word;
        if (idx_q == last_idx) begin
          dv_q <= 1'b1;
        end
      end else begin
        // Link-detect bits: config bit 1 then config bits 7..4
        if (idx_q == LINK_WORD) begin
          data_q[20:16] <= {rdata_q[15:12], rdata_q[9]};
        end
        if (idx_q == ALIAS_WORD) begin
          data_q[15:0] <= rdata_q;
        end
        if (idx_q == CHECK_WORD) begin
          if (crc == rdata_q[7:0]) begin
            dv_q <= 1'b1;
          end else begin
            serr_q <= 1'b1;
            data_q <= '0;
          end
        end
      end
    end
    if (out_load) begin
      m_data_q <= {4'b0000, serr_q, cerr_q, data_q, dv_q, ack_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef SYNTHESIS
  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !m_axis_tvalid)
    else $error("result offered during store clearing");

  a_store_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_wa} < STORE_LIMIT[AW:0]))
    else $error("store write outside the store");

  a_checksum_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[67]) |-> (!m_axis_tdata[1] && (m_axis_tdata[65:2] == 64'd0)))
    else $error("checksum error carries data");

  a_read_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_USE) && (op_q == OP_READ)) |-> (idx_q <= 3'd3))
    else $error("read word index past four words");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("sequencer idle right after accept");
`endif

endmodule
`default_nettype wire
